[design/s5rp_pkg.sv]
// Shared types and constants for the SOCKS5 request parser.
// Used by every module of the block and by its port checker; no dependencies.
package s5rp_pkg;

    localparam logic       CMD_PARSE     = 1'b0;
    localparam logic       CMD_RESTART   = 1'b1;

    localparam logic [7:0] SOCKS_VERSION = 8'd5;
    localparam logic [7:0] CMD_CONNECT   = 8'd1;
    localparam logic [7:0] RSV_VALUE     = 8'h00;
    localparam logic [7:0] ATYP_IPV4     = 8'd1;
    localparam logic [7:0] ATYP_DOMAIN   = 8'd3;
    localparam logic [7:0] ATYP_IPV6     = 8'd4;
    localparam logic [7:0] IPV4_LEN      = 8'd4;
    localparam logic [7:0] IPV6_LEN      = 8'd16;

    localparam logic [2:0] KIND_NONE     = 3'd0;
    localparam logic [2:0] KIND_IPV4     = 3'd1;
    localparam logic [2:0] KIND_DOMAIN   = 3'd3;
    localparam logic [2:0] KIND_IPV6     = 3'd4;

    localparam logic [1:0] STATUS_BUSY   = 2'd0;
    localparam logic [1:0] STATUS_DONE   = 2'd1;
    localparam logic [1:0] STATUS_ERROR  = 2'd2;

    localparam logic [2:0] CAUSE_NONE    = 3'd0;
    localparam logic [2:0] CAUSE_VERSION = 3'd1;
    localparam logic [2:0] CAUSE_COMMAND = 3'd2;
    localparam logic [2:0] CAUSE_RSV     = 3'd3;
    localparam logic [2:0] CAUSE_ATYP    = 3'd4;
    localparam logic [2:0] CAUSE_ZLEN    = 3'd5;

    typedef enum logic [11:0] {
        PH_VERSION = 12'b0000_0000_0001,
        PH_CMD     = 12'b0000_0000_0010,
        PH_RSV     = 12'b0000_0000_0100,
        PH_ATYP    = 12'b0000_0000_1000,
        PH_DLEN    = 12'b0000_0001_0000,
        PH_IPV4    = 12'b0000_0010_0000,
        PH_IPV6    = 12'b0000_0100_0000,
        PH_DOMAIN  = 12'b0000_1000_0000,
        PH_PHIGH   = 12'b0001_0000_0000,
        PH_PLOW    = 12'b0010_0000_0000,
        PH_DONE    = 12'b0100_0000_0000,
        PH_ERROR   = 12'b1000_0000_0000
    } phase_t;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  error_cause;
        logic        address_byte_valid;
        logic [7:0]  address_byte;
        logic [7:0]  address_index;
        logic        address_last;
        logic [2:0]  address_kind;
        logic [7:0]  name_length;
        logic [15:0] dest_port;
    } result_t;

endpackage

[design/socks5_request_parser_core.sv]
// SOCKS5 CONNECT request parser. Takes one request byte per transfer and returns one result
// per byte: status, error cause, the destination address byte with its index and last mark,
// the address type, the domain name length and, once complete, the port. A byte passes
// through the input register, then the result register, and a new byte is taken every cycle
// while the result side keeps up; the rate is set by the single state update per byte. After
// completion or error, bytes are ignored until a restart.
// Depends on s5rp_pkg, s5rp_in_reg, s5rp_parse and s5rp_out_reg.
module socks5_request_parser_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [2:0]  m_error_cause,
    output logic        m_address_byte_valid,
    output logic [7:0]  m_address_byte,
    output logic [7:0]  m_address_index,
    output logic        m_address_last,
    output logic [2:0]  m_address_kind,
    output logic [7:0]  m_name_length,
    output logic [15:0] m_dest_port
);
    import s5rp_pkg::*;

    logic    item_valid;
    logic    advance;
    item_t   item;
    result_t res;
    result_t res_out;

    // advance when the result register is free or being emptied this cycle
    assign advance = item_valid && (!m_valid || m_ready);

    s5rp_in_reg u_in_reg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_data_byte (s_data_byte),
        .advance     (advance),
        .item_valid  (item_valid),
        .item        (item)
    );

    s5rp_parse u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item),
        .res     (res)
    );

    s5rp_out_reg u_out_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (advance),
        .res     (res),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .res_out (res_out)
    );

    assign m_status             = res_out.status;
    assign m_error_cause        = res_out.error_cause;
    assign m_address_byte_valid = res_out.address_byte_valid;
    assign m_address_byte       = res_out.address_byte;
    assign m_address_index      = res_out.address_index;
    assign m_address_last       = res_out.address_last;
    assign m_address_kind       = res_out.address_kind;
    assign m_name_length        = res_out.name_length;
    assign m_dest_port          = res_out.dest_port;

endmodule

[design/s5rp_in_reg.sv]
// Input register of the SOCKS5 request parser: holds one accepted transfer.
// Depends on s5rp_pkg.
module s5rp_in_reg (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic           s_cmd,
    input  logic [7:0]     s_data_byte,
    input  logic           advance,
    output logic           item_valid,
    output s5rp_pkg::item_t item
);
    import s5rp_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    assign s_ready    = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            valid_reg <= 1'b1;
        end else if (advance) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.cmd       <= s_cmd;
            item_reg.data_byte <= s_data_byte;
        end
    end

endmodule

[design/s5rp_parse.sv]
// Request state machine of the SOCKS5 parser: one byte per step, one result per byte.
// Depends on s5rp_pkg.
module s5rp_parse (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  s5rp_pkg::item_t   item,
    output s5rp_pkg::result_t res
);
    import s5rp_pkg::*;

    phase_t      phase_reg,  phase_next;
    logic [2:0]  kind_reg,   kind_next;
    logic [7:0]  taken_reg,  taken_next;
    logic [7:0]  dlen_reg,   dlen_next;
    logic [15:0] port_reg,   port_next;
    logic [2:0]  fault_reg,  fault_next;
    logic [7:0]  taken_inc;
    logic [7:0]  total;
    logic [7:0]  b;
    logic        addr_byte;
    logic        addr_last;
    logic [1:0]  status;

    assign b         = item.data_byte;
    assign taken_inc = taken_reg + 8'd1;

    always_comb begin
        case (phase_reg)
            PH_IPV4: total = IPV4_LEN;
            PH_IPV6: total = IPV6_LEN;
            default: total = dlen_reg;
        endcase
    end

    always_comb begin
        phase_next = phase_reg;
        kind_next  = kind_reg;
        taken_next = taken_reg;
        dlen_next  = dlen_reg;
        port_next  = port_reg;
        fault_next = fault_reg;
        addr_byte  = 1'b0;
        addr_last  = 1'b0;
        if (item.cmd == CMD_RESTART) begin
            phase_next = PH_VERSION;
            kind_next  = KIND_NONE;
            taken_next = '0;
            dlen_next  = '0;
            port_next  = '0;
            fault_next = CAUSE_NONE;
        end else begin
            case (phase_reg)
                PH_VERSION: begin
                    if (b != SOCKS_VERSION) begin
                        phase_next = PH_ERROR;
                        fault_next = CAUSE_VERSION;
                    end else begin
                        phase_next = PH_CMD;
                    end
                end
                PH_CMD: begin
                    if (b != CMD_CONNECT) begin
                        phase_next = PH_ERROR;
                        fault_next = CAUSE_COMMAND;
                    end else begin
                        phase_next = PH_RSV;
                    end
                end
                PH_RSV: begin
                    if (b != RSV_VALUE) begin
                        phase_next = PH_ERROR;
                        fault_next = CAUSE_RSV;
                    end else begin
                        phase_next = PH_ATYP;
                    end
                end
                PH_ATYP: begin
                    taken_next = '0;
                    if (b == ATYP_IPV4) begin
                        kind_next  = KIND_IPV4;
                        phase_next = PH_IPV4;
                    end else if (b == ATYP_IPV6) begin
                        kind_next  = KIND_IPV6;
                        phase_next = PH_IPV6;
                    end else if (b == ATYP_DOMAIN) begin
                        kind_next  = KIND_DOMAIN;
                        phase_next = PH_DLEN;
                    end else begin
                        phase_next = PH_ERROR;
                        fault_next = CAUSE_ATYP;
                    end
                end
                PH_DLEN: begin
                    if (b == 8'd0) begin
                        phase_next = PH_ERROR;
                        fault_next = CAUSE_ZLEN;
                    end else begin
                        dlen_next  = b;
                        taken_next = '0;
                        phase_next = PH_DOMAIN;
                    end
                end
                PH_IPV4, PH_IPV6, PH_DOMAIN: begin
                    addr_byte  = 1'b1;
                    taken_next = taken_inc;
                    if (taken_inc == total) begin
                        addr_last  = 1'b1;
                        phase_next = PH_PHIGH;
                    end
                end
                PH_PHIGH: begin
                    port_next  = {b, 8'h00};
                    phase_next = PH_PLOW;
                end
                PH_PLOW: begin
                    port_next  = {port_reg[15:8], b};
                    phase_next = PH_DONE;
                end
                PH_DONE: begin
                    phase_next = PH_DONE;
                end
                default: begin
                    phase_next = PH_ERROR;
                end
            endcase
        end
    end

    always_comb begin
        if (phase_next == PH_DONE) begin
            status = STATUS_DONE;
        end else if (phase_next == PH_ERROR) begin
            status = STATUS_ERROR;
        end else begin
            status = STATUS_BUSY;
        end
        res.status             = status;
        res.error_cause        = (status == STATUS_ERROR) ? fault_next : CAUSE_NONE;
        res.address_byte_valid = addr_byte;
        res.address_byte       = addr_byte ? b : 8'd0;
        res.address_index      = addr_byte ? taken_reg : 8'd0;
        res.address_last       = addr_last;
        res.address_kind       = kind_next;
        res.name_length        = dlen_next;
        res.dest_port          = (status == STATUS_DONE) ? port_next : 16'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_VERSION;
            kind_reg  <= KIND_NONE;
            taken_reg <= '0;
            dlen_reg  <= '0;
            port_reg  <= '0;
            fault_reg <= CAUSE_NONE;
        end else if (advance) begin
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            taken_reg <= taken_next;
            dlen_reg  <= dlen_next;
            port_reg  <= port_next;
            fault_reg <= fault_next;
        end
    end

endmodule

[design/s5rp_out_reg.sv]
// Result register of the SOCKS5 request parser: holds one result until transfer.
// Depends on s5rp_pkg.
module s5rp_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  s5rp_pkg::result_t res,
    input  logic              m_ready,
    output logic              m_valid,
    output s5rp_pkg::result_t res_out
);
    import s5rp_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    assign m_valid = valid_reg;
    assign res_out = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

endmodule

[design/s5rp_checker.sv]
// Port-level checks for socks5_request_parser_core, with the bind that attaches them.
// Depends on s5rp_pkg and socks5_request_parser_core.
module s5rp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_status,
    input logic [2:0]  m_error_cause,
    input logic        m_address_byte_valid,
    input logic        m_address_last,
    input logic [15:0] m_dest_port
);
    import s5rp_pkg::*;

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_dest_port))
        else $error("stalled result changed");

    a_cause_only_on_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STATUS_ERROR |-> m_error_cause == CAUSE_NONE)
        else $error("error cause without error status");

    a_addr_in_progress: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_address_byte_valid || m_address_last) |->
            m_address_byte_valid && m_status == STATUS_BUSY)
        else $error("address byte outside request body");

    a_port_only_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STATUS_DONE |-> m_dest_port == 16'd0)
        else $error("port shown before completion");

endmodule

bind socks5_request_parser_core s5rp_checker u_s5rp_checker (
    .aclk                 (aclk),
    .aresetn              (aresetn),
    .m_valid              (m_valid),
    .m_ready              (m_ready),
    .m_status             (m_status),
    .m_error_cause        (m_error_cause),
    .m_address_byte_valid (m_address_byte_valid),
    .m_address_last       (m_address_last),
    .m_dest_port          (m_dest_port)
);

[sim/s5rp_port_checker.sv]
// Port checker for the SOCKS5 request parser: predicts one result per input transfer
// and compares every result transfer against the oldest prediction.
// Depends on s5rp_pkg.
`timescale 1ns / 100ps

module s5rp_port_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_cmd,
    input  logic [7:0]  s_data_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_status,
    input  logic [2:0]  m_error_cause,
    input  logic        m_address_byte_valid,
    input  logic [7:0]  m_address_byte,
    input  logic [7:0]  m_address_index,
    input  logic        m_address_last,
    input  logic [2:0]  m_address_kind,
    input  logic [7:0]  m_name_length,
    input  logic [15:0] m_dest_port,
    output int          fail_count,
    output int          pending_count
);
    import s5rp_pkg::*;

    phase_t      parse_phase;
    logic [2:0]  seen_kind;
    logic [7:0]  addr_count;
    logic [7:0]  domain_length;
    logic [15:0] port_word;
    logic [2:0]  fault_cause;

    result_t     expected_results[$];

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        fail_count++;
    endtask

    task automatic compare_field(input string name, input int unsigned got_v,
                                 input int unsigned want_v);
        if (got_v != want_v)
            report_mismatch($sformatf("%s got %0d want %0d", name, got_v, want_v));
    endtask

    function automatic void clear_parse_state();
        parse_phase   = PH_VERSION;
        seen_kind     = KIND_NONE;
        addr_count    = '0;
        domain_length = '0;
        port_word     = '0;
        fault_cause   = CAUSE_NONE;
    endfunction

    function automatic result_t predict_parse_result(input logic cmd, input logic [7:0] b);
        result_t    r;
        logic [7:0] total;
        r = '0;
        if (cmd == CMD_RESTART) begin
            clear_parse_state();
            return r;
        end
        case (parse_phase)
            PH_VERSION: begin
                if (b != SOCKS_VERSION) begin
                    parse_phase = PH_ERROR;
                    fault_cause = CAUSE_VERSION;
                end else begin
                    parse_phase = PH_CMD;
                end
            end
            PH_CMD: begin
                if (b != CMD_CONNECT) begin
                    parse_phase = PH_ERROR;
                    fault_cause = CAUSE_COMMAND;
                end else begin
                    parse_phase = PH_RSV;
                end
            end
            PH_RSV: begin
                if (b != RSV_VALUE) begin
                    parse_phase = PH_ERROR;
                    fault_cause = CAUSE_RSV;
                end else begin
                    parse_phase = PH_ATYP;
                end
            end
            PH_ATYP: begin
                addr_count = '0;
                if (b == ATYP_IPV4) begin
                    seen_kind   = KIND_IPV4;
                    parse_phase = PH_IPV4;
                end else if (b == ATYP_IPV6) begin
                    seen_kind   = KIND_IPV6;
                    parse_phase = PH_IPV6;
                end else if (b == ATYP_DOMAIN) begin
                    seen_kind   = KIND_DOMAIN;
                    parse_phase = PH_DLEN;
                end else begin
                    parse_phase = PH_ERROR;
                    fault_cause = CAUSE_ATYP;
                end
            end
            PH_DLEN: begin
                if (b == 8'd0) begin
                    parse_phase = PH_ERROR;
                    fault_cause = CAUSE_ZLEN;
                end else begin
                    domain_length = b;
                    addr_count    = '0;
                    parse_phase   = PH_DOMAIN;
                end
            end
            PH_IPV4, PH_IPV6, PH_DOMAIN: begin
                total = (parse_phase == PH_IPV4) ? IPV4_LEN :
                        (parse_phase == PH_IPV6) ? IPV6_LEN : domain_length;
                r.address_byte_valid = 1'b1;
                r.address_byte       = b;
                r.address_index      = addr_count;
                addr_count           = addr_count + 8'd1;
                if (addr_count == total) begin
                    r.address_last = 1'b1;
                    parse_phase    = PH_PHIGH;
                end
            end
            PH_PHIGH: begin
                port_word   = {b, 8'h00};
                parse_phase = PH_PLOW;
            end
            PH_PLOW: begin
                port_word[7:0] = b;
                parse_phase    = PH_DONE;
            end
            PH_DONE, PH_ERROR: begin
            end
            default: parse_phase = PH_ERROR;
        endcase

        if (parse_phase == PH_DONE)
            r.status = STATUS_DONE;
        else if (parse_phase == PH_ERROR)
            r.status = STATUS_ERROR;
        else
            r.status = STATUS_BUSY;
        r.error_cause  = (r.status == STATUS_ERROR) ? fault_cause : CAUSE_NONE;
        r.address_kind = seen_kind;
        r.name_length  = domain_length;
        r.dest_port    = (r.status == STATUS_DONE) ? port_word : 16'd0;
        return r;
    endfunction

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (!aresetn) begin
            clear_parse_state();
            expected_results.delete();
            fail_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                got.status             = m_status;
                got.error_cause        = m_error_cause;
                got.address_byte_valid = m_address_byte_valid;
                got.address_byte       = m_address_byte;
                got.address_index      = m_address_index;
                got.address_last       = m_address_last;
                got.address_kind       = m_address_kind;
                got.name_length        = m_name_length;
                got.dest_port          = m_dest_port;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result transfer with nothing outstanding, status %0d",
                                              got.status));
                end else begin
                    want = expected_results.pop_front();
                    compare_field("status", got.status, want.status);
                    compare_field("error_cause", got.error_cause, want.error_cause);
                    compare_field("address_byte_valid", got.address_byte_valid,
                                  want.address_byte_valid);
                    compare_field("address_byte", got.address_byte, want.address_byte);
                    compare_field("address_index", got.address_index, want.address_index);
                    compare_field("address_last", got.address_last, want.address_last);
                    compare_field("address_kind", got.address_kind, want.address_kind);
                    compare_field("name_length", got.name_length, want.name_length);
                    compare_field("dest_port", got.dest_port, want.dest_port);
                end
            end
            if (s_valid && s_ready)
                expected_results.push_back(predict_parse_result(s_cmd, s_data_byte));
        end
        pending_count = expected_results.size();
    end

endmodule

[sim/tb_socks5_request_parser_core.sv]
// Top of the SOCKS5 request parser testbench: clock, reset, request stimulus, result-side
// backpressure, watchdog and verdict.
// Depends on s5rp_pkg, socks5_request_parser_core and s5rp_port_checker.
`timescale 1ns / 100ps

module tb_socks5_request_parser_core;
    import s5rp_pkg::*;

    localparam int ITEM_TARGET = 1300;
    localparam int TAIL_START  = 1150;
    localparam int IDLE_LIMIT  = 500;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic        s_cmd       = CMD_PARSE;
    logic [7:0]  s_data_byte = 8'h00;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [1:0]  m_status;
    logic [2:0]  m_error_cause;
    logic        m_address_byte_valid;
    logic [7:0]  m_address_byte;
    logic [7:0]  m_address_index;
    logic        m_address_last;
    logic [2:0]  m_address_kind;
    logic [7:0]  m_name_length;
    logic [15:0] m_dest_port;

    int          fail_count;
    int          pending_count;
    int          items_sent  = 0;
    int          idle_cycles = 0;
    int          rx_cycle    = 0;
    int          rx_stall    = 0;
    bit          calm_tail   = 1'b0;
    bit          sender_idle = 1'b0;
    logic [7:0]  request_bytes[$];

    socks5_request_parser_core DUT (.*);

    s5rp_port_checker port_checker (.*);

    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    task automatic send_item(input logic cmd, input logic [7:0] b);
        if (sender_idle && !calm_tail && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_cmd       <= cmd;
        s_data_byte <= b;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    function automatic logic [7:0] port_octet();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic build_request();
        int         len;
        int         cut;
        logic [7:0] atyp;
        request_bytes.delete();
        request_bytes.push_back(SOCKS_VERSION);
        request_bytes.push_back(CMD_CONNECT);
        request_bytes.push_back(RSV_VALUE);
        case ($urandom_range(0, 2))
            0: begin
                atyp = ATYP_IPV4;
                len  = int'(IPV4_LEN);
            end
            1: begin
                atyp = ATYP_IPV6;
                len  = int'(IPV6_LEN);
            end
            default: begin
                atyp = ATYP_DOMAIN;
                if ($urandom_range(0, 15) == 0)
                    len = 255;
                else if ($urandom_range(0, 7) == 0)
                    len = $urandom_range(1, 255);
                else
                    len = $urandom_range(1, 12);
            end
        endcase
        request_bytes.push_back(atyp);
        if (atyp == ATYP_DOMAIN)
            request_bytes.push_back(8'(len));
        repeat (len) request_bytes.push_back(8'($urandom));
        request_bytes.push_back(port_octet());
        request_bytes.push_back(port_octet());

        // break some requests: corrupt a header byte or truncate
        case ($urandom_range(0, 9))
            0: request_bytes[$urandom_range(0, (atyp == ATYP_DOMAIN) ? 4 : 3)] = 8'($urandom);
            1: begin
                cut = $urandom_range(1, request_bytes.size() - 1);
                repeat (cut) void'(request_bytes.pop_back());
            end
            default: ;
        endcase
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) request_bytes.push_back(8'($urandom));
    endtask

    // result side: random short stalls, two long hold-offs, none in the tail
    always @(posedge aclk) begin
        if (!aresetn) begin
            rx_cycle = 0;
            rx_stall = 0;
            m_ready <= 1'b0;
        end else begin
            rx_cycle++;
            if (!calm_tail && (rx_cycle == 300 || rx_cycle == 1200))
                rx_stall = 64;
            else if (!calm_tail && rx_stall == 0 && rx_cycle[6] && $urandom_range(0, 5) == 0)
                rx_stall = $urandom_range(1, 4);
            if (rx_stall > 0) begin
                m_ready <= 1'b0;
                rx_stall--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // version error and a byte ignored after it, then command, RSV, ATYP and zero-length errors
        send_item(CMD_PARSE, 8'h06);
        send_item(CMD_PARSE, 8'hFF);
        send_item(CMD_RESTART, 8'hFF);
        send_item(CMD_PARSE, SOCKS_VERSION);
        send_item(CMD_PARSE, 8'h02);
        send_item(CMD_RESTART, 8'h00);
        send_item(CMD_PARSE, SOCKS_VERSION);
        send_item(CMD_PARSE, CMD_CONNECT);
        send_item(CMD_PARSE, 8'h01);
        send_item(CMD_RESTART, 8'hA5);
        send_item(CMD_PARSE, SOCKS_VERSION);
        send_item(CMD_PARSE, CMD_CONNECT);
        send_item(CMD_PARSE, RSV_VALUE);
        send_item(CMD_PARSE, 8'h02);
        send_item(CMD_RESTART, 8'h5A);
        send_item(CMD_PARSE, SOCKS_VERSION);
        send_item(CMD_PARSE, CMD_CONNECT);
        send_item(CMD_PARSE, RSV_VALUE);
        send_item(CMD_PARSE, ATYP_DOMAIN);
        send_item(CMD_PARSE, 8'h00);

        while (items_sent < ITEM_TARGET) begin
            sender_idle = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 19) == 0) begin
                repeat ($urandom_range(1, 6)) send_item(CMD_PARSE, 8'($urandom));
            end else begin
                if ($urandom_range(0, 9) != 0)
                    send_item(CMD_RESTART, 8'($urandom));
                build_request();
                foreach (request_bytes[i])
                    send_item(CMD_PARSE, request_bytes[i]);
            end
            if (items_sent >= TAIL_START)
                calm_tail <= 1'b1;
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (fail_count == 0 && pending_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
